>>> sv/pmo_pkg.sv
// ----------------------------------------------------------------------------
// pmo_pkg: shared types and constants for the proportional move block
// Field widths, the request and result payloads, register indexes and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmo_pkg;

  localparam int AXES       = 3;
  localparam int AXW        = 2;
  localparam int POS_W      = 32;
  localparam int GOAL_W     = 24;
  localparam int VEL_W      = 20;
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int TOL_W      = 16;
  localparam int DRV_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_Z      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SWITCH = 3'd5;

  // axis select codes
  localparam logic [AXW-1:0] AX_X = 2'd0;
  localparam logic [AXW-1:0] AX_Y = 2'd1;
  localparam logic [AXW-1:0] AX_Z = 2'd2;

  // request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [GOAL_W-1:0] target_x;
    logic signed [GOAL_W-1:0] target_y;
    logic signed [GOAL_W-1:0] target_z;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_z;
    logic [DT_W-1:0]          tick_time;
    logic                     touch;
  } pmo_in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive_x;
    logic signed [DRV_W-1:0] drive_y;
    logic signed [DRV_W-1:0] drive_z;
    logic                    arrived;
    logic                    switch_stop;
  } pmo_out_t;

  typedef struct packed {
    logic           load;
    logic           int_mul;
    logic           int_add;
    logic           err;
    logic           drv_mul;
    logic           drv_sat;
    logic           fin;
    logic           last;
    logic [AXW-1:0] axis;
  } pmo_cmd_t;

  typedef struct packed {
    logic start_item;
    logic idle_tick;
  } pmo_sts_t;

endpackage

>>> sv/pmo_datapath.sv
// ----------------------------------------------------------------------------
// pmo_datapath: odometry and drive arithmetic, one axis per step
// Holds configuration, goal, position and velocity history, a shared
// integration multiplier, a shared gain multiplier and the result register.
// ----------------------------------------------------------------------------
module pmo_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pmo_pkg::pmo_in_t                    in_data,
  input  logic                                cfg_we,
  input  logic [pmo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  pmo_pkg::pmo_cmd_t                   cmd,
  output pmo_pkg::pmo_sts_t                   sts,
  output pmo_pkg::pmo_out_t                   out_data
);

  localparam int IPROD_W   = pmo_pkg::DT_W + 1 + pmo_pkg::VEL_W + 1;
  localparam int INT_SHIFT = 17;
  localparam int INC_W     = IPROD_W - INT_SHIFT;
  localparam int ERR_W     = pmo_pkg::POS_W + 1;
  localparam int DPROD_W   = ERR_W + pmo_pkg::GAIN_W + 1;
  localparam int DRV_SHIFT = 8;
  localparam int DSH_W     = DPROD_W - DRV_SHIFT;

  localparam logic signed [IPROD_W-1:0] INT_HALF = IPROD_W'(64'd1 << (INT_SHIFT - 1));
  localparam logic signed [DPROD_W-1:0] DRV_HALF = DPROD_W'(64'd1 << (DRV_SHIFT - 1));
  localparam logic signed [pmo_pkg::POS_W-1:0] POS_MAX = {1'b0, {(pmo_pkg::POS_W-1){1'b1}}};
  localparam logic signed [pmo_pkg::POS_W-1:0] POS_MIN = {1'b1, {(pmo_pkg::POS_W-1){1'b0}}};
  localparam logic signed [pmo_pkg::DRV_W-1:0] DRV_MAX = {1'b0, {(pmo_pkg::DRV_W-1){1'b1}}};
  localparam logic signed [pmo_pkg::DRV_W-1:0] DRV_MIN = {1'b1, {(pmo_pkg::DRV_W-1){1'b0}}};

  // configuration
  logic [pmo_pkg::GAIN_W-1:0] gain_r;
  logic [pmo_pkg::TOL_W-1:0]  tol_r [pmo_pkg::AXES];
  logic                       use_z_r;
  logic                       use_sw_r;

  // move state
  logic signed [pmo_pkg::GOAL_W-1:0] goal_r [pmo_pkg::AXES];
  logic signed [pmo_pkg::POS_W-1:0]  pos_r  [pmo_pkg::AXES];
  logic signed [pmo_pkg::VEL_W-1:0]  lv_r   [pmo_pkg::AXES];
  logic                              first_r;
  logic                              moving_r;

  // per-request working registers
  pmo_pkg::pmo_in_t                  itm_r;
  logic                              idle_r;
  logic                              within_r;
  logic signed [IPROD_W-1:0]         iprod_r;
  logic signed [ERR_W-1:0]           err_r;
  logic signed [DPROD_W-1:0]         dprod_r;
  logic signed [pmo_pkg::DRV_W-1:0]  drive_r [pmo_pkg::AXES];
  pmo_pkg::pmo_out_t                 out_r;

  logic signed [pmo_pkg::VEL_W-1:0]  v_sel;
  logic signed [pmo_pkg::VEL_W:0]    vsum;
  logic signed [IPROD_W-1:0]         iprod_nxt;
  logic signed [IPROD_W-1:0]         irnd;
  logic signed [INC_W-1:0]           inc;
  logic signed [pmo_pkg::POS_W:0]    psum;
  logic signed [pmo_pkg::POS_W-1:0]  psat;
  logic signed [ERR_W-1:0]           err_nxt;
  logic [ERR_W-1:0]                  mag;
  logic                              chk;
  logic                              too_far;
  logic signed [DPROD_W-1:0]         dprod_nxt;
  logic signed [DPROD_W-1:0]         drnd;
  logic signed [DSH_W-1:0]           dsh;
  logic [DSH_W-pmo_pkg::DRV_W:0]     dhi;
  logic signed [pmo_pkg::DRV_W-1:0]  dsat;
  logic                              sw;
  logic                              done;

  always_comb begin
    unique case (cmd.axis)
      pmo_pkg::AX_X: v_sel = itm_r.vel_x;
      pmo_pkg::AX_Y: v_sel = itm_r.vel_y;
      default:       v_sel = itm_r.vel_z;
    endcase
  end

  // trapezoid increment: dt * (v + last_v), round half up by 2^17
  assign vsum      = (pmo_pkg::VEL_W+1)'(v_sel) + (pmo_pkg::VEL_W+1)'(lv_r[cmd.axis]);
  assign iprod_nxt = IPROD_W'($signed({1'b0, itm_r.tick_time})) * IPROD_W'(vsum);
  assign irnd      = iprod_r + INT_HALF;
  assign inc       = irnd[IPROD_W-1:INT_SHIFT];
  assign psum      = (pmo_pkg::POS_W+1)'(pos_r[cmd.axis]) + (pmo_pkg::POS_W+1)'(inc);
  assign psat      = (psum[pmo_pkg::POS_W] != psum[pmo_pkg::POS_W-1]) ?
                     (psum[pmo_pkg::POS_W] ? POS_MIN : POS_MAX) :
                     psum[pmo_pkg::POS_W-1:0];

  // error and tolerance check
  assign err_nxt = ERR_W'(goal_r[cmd.axis]) - ERR_W'(pos_r[cmd.axis]);
  assign mag     = err_nxt[ERR_W-1] ? $unsigned(-err_nxt) : $unsigned(err_nxt);
  assign chk     = (cmd.axis != pmo_pkg::AX_Z) || use_z_r;
  assign too_far = chk && (mag > ERR_W'(tol_r[cmd.axis]));

  // drive: error * gain, round half up by 2^8, saturate
  assign dprod_nxt = DPROD_W'(err_r) * DPROD_W'($signed({1'b0, gain_r}));
  assign drnd      = dprod_r + DRV_HALF;
  assign dsh       = drnd[DPROD_W-1:DRV_SHIFT];
  assign dhi       = dsh[DSH_W-1:pmo_pkg::DRV_W-1];
  assign dsat      = ((&dhi) || !(|dhi)) ? dsh[pmo_pkg::DRV_W-1:0] :
                     (dsh[DSH_W-1] ? DRV_MIN : DRV_MAX);

  assign sw   = use_sw_r && itm_r.touch;
  assign done = within_r || sw;

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= pmo_pkg::GAIN_W'(256);
      tol_r[0] <= pmo_pkg::TOL_W'(256);
      tol_r[1] <= pmo_pkg::TOL_W'(256);
      tol_r[2] <= pmo_pkg::TOL_W'(256);
      use_z_r  <= 1'b0;
      use_sw_r <= 1'b0;
      first_r  <= 1'b1;
      moving_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pmo_pkg::CFG_GAIN:       gain_r   <= cfg_data;
          pmo_pkg::CFG_TOL_X:      tol_r[0] <= cfg_data;
          pmo_pkg::CFG_TOL_Y:      tol_r[1] <= cfg_data;
          pmo_pkg::CFG_TOL_Z:      tol_r[2] <= cfg_data;
          pmo_pkg::CFG_USE_Z:      use_z_r  <= cfg_data[0];
          pmo_pkg::CFG_USE_SWITCH: use_sw_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load && (in_data.action == pmo_pkg::ACT_START)) begin
        first_r  <= 1'b1;
        moving_r <= 1'b1;
      end
      if (cmd.int_add && cmd.last) begin
        first_r <= 1'b0;
      end
      if (cmd.fin && !idle_r && done) begin
        moving_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm_r    <= in_data;
      idle_r   <= (in_data.action == pmo_pkg::ACT_TICK) && !moving_r;
      within_r <= 1'b1;
      if (in_data.action == pmo_pkg::ACT_START) begin
        goal_r[0] <= in_data.target_x;
        goal_r[1] <= in_data.target_y;
        goal_r[2] <= in_data.target_z;
        for (int a = 0; a < pmo_pkg::AXES; a++) begin
          pos_r[a] <= '0;
          lv_r[a]  <= '0;
        end
      end
    end
    if (cmd.int_mul) begin
      iprod_r <= iprod_nxt;
    end
    if (cmd.int_add) begin
      if (!first_r) begin
        pos_r[cmd.axis] <= psat;
      end
      lv_r[cmd.axis] <= v_sel;
    end
    if (cmd.err) begin
      err_r <= err_nxt;
      if (too_far) begin
        within_r <= 1'b0;
      end
    end
    if (cmd.drv_mul) begin
      dprod_r <= dprod_nxt;
    end
    if (cmd.drv_sat) begin
      drive_r[cmd.axis] <= ((cmd.axis == pmo_pkg::AX_Z) && !use_z_r) ? '0 : dsat;
    end
    if (cmd.fin) begin
      if (idle_r) begin
        out_r <= '0;
      end else if (done) begin
        out_r <= '{drive_x: '0, drive_y: '0, drive_z: '0,
                   arrived: within_r, switch_stop: sw};
      end else begin
        out_r <= '{drive_x: drive_r[0], drive_y: drive_r[1], drive_z: drive_r[2],
                   arrived: 1'b0, switch_stop: 1'b0};
      end
    end
  end

  assign sts.start_item = (itm_r.action == pmo_pkg::ACT_START);
  assign sts.idle_tick  = idle_r;
  assign out_data       = out_r;

endmodule

>>> sv/pmo_ctrl.sv
// ----------------------------------------------------------------------------
// pmo_ctrl: sequencer for the proportional move block
// Walks the axes through integration and drive steps and owns the
// request and result handshakes.
// ----------------------------------------------------------------------------
module pmo_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pmo_pkg::pmo_sts_t   sts,
  output pmo_pkg::pmo_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_IMUL = 8'b0000_0100,
    S_IADD = 8'b0000_1000,
    S_ERR  = 8'b0001_0000,
    S_DMUL = 8'b0010_0000,
    S_DSAT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [pmo_pkg::AXW-1:0]    axis_r, axis_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        axis_nxt = pmo_pkg::AX_X;
        priority if (sts.idle_tick) begin
          state_nxt = S_FIN;
        end else if (sts.start_item) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: begin
        cmd.int_mul = 1'b1;
        state_nxt   = S_IADD;
      end
      S_IADD: begin
        cmd.int_add = 1'b1;
        if (axis_r == pmo_pkg::AX_Z) begin
          cmd.last  = 1'b1;
          axis_nxt  = pmo_pkg::AX_X;
          state_nxt = S_ERR;
        end else begin
          axis_nxt  = axis_r + pmo_pkg::AXW'(1);
          state_nxt = S_IMUL;
        end
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.drv_mul = 1'b1;
        state_nxt   = S_DSAT;
      end
      S_DSAT: begin
        cmd.drv_sat = 1'b1;
        if (axis_r == pmo_pkg::AX_Z) begin
          axis_nxt  = pmo_pkg::AX_X;
          state_nxt = S_FIN;
        end else begin
          axis_nxt  = axis_r + pmo_pkg::AXW'(1);
          state_nxt = S_ERR;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= pmo_pkg::AX_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/proportional_move_with_odometry.sv
// ----------------------------------------------------------------------------
// proportional_move_with_odometry: relative 3-axis move, P control + odometry
// Integrates measured velocities by the trapezoid rule and issues saturated
// proportional drive commands until the target is reached or a switch trips.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall/in_data): a start request loads the
//   relative target and clears position; a tick request brings velocities,
//   elapsed time and the switch state. Every request yields one result on
//   the result channel (out_valid/out_stall/out_data).
//   Configuration (cfg_we/cfg_index/cfg_data) writes gain, tolerances and
//   the z-axis and switch enables; write only while the block is idle.
// Timing:
//   The block works on one request at a time; in_stall is low only while it
//   waits for a request. A tick during a move runs two steps per axis on the
//   shared integration multiplier, then three steps per axis on the shared
//   gain multiplier, between dispatch and result load; a start skips the
//   integration steps, and a tick with no move active goes from dispatch
//   straight to the result load. The next request is taken only once the
//   result is registered, so a move advances one tick at a time.
//   A stalled result sits in the output register; the next request is still
//   accepted and processed, and it waits only for that register to empty.
// Reset: clears gain to 1.0, tolerances to 256, both enables and the move,
//   and drops any pending result.
// ----------------------------------------------------------------------------
module proportional_move_with_odometry (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pmo_pkg::pmo_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pmo_pkg::pmo_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [pmo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pmo_pkg::pmo_cmd_t cmd;
  pmo_pkg::pmo_sts_t sts;

  // sequencer: handshakes and per-axis step order
  pmo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, move state and result register
  pmo_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // one request in flight: an accepted request blocks the next cycle
  a_one_in_flight : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("request accepted while another is in work");

  // an ended move reports zero drive on every axis
  a_stop_zero_drive : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.arrived || out_data.switch_stop)) |->
      ((out_data.drive_x == '0) && (out_data.drive_y == '0) && (out_data.drive_z == '0))
  ) else $error("nonzero drive on ending result");

  // a new result only appears after the sequencer was busy
  a_result_from_work : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result without a request in work");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for proportional_move_with_odometry
// Drives start and tick requests over the valid/stall channel, predicts each
// result from an in-bench copy of the move state, and compares every field.
// ----------------------------------------------------------------------------
module testbench;
  import pmo_pkg::*;

  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     SETTLE_CYCLES = 24;     // longest request latency plus margin
  localparam int     DIRECT_TICK   = 1;
  localparam int     PHASES        = 8;
  localparam int     PHASE_ITEMS   = 65;
  localparam longint POS_MAX       = 64'sd2147483647;
  localparam longint POS_MIN       = -POS_MAX - 1;
  localparam longint DRV_MAX       = 64'sd8388607;
  localparam longint DRV_MIN       = -DRV_MAX - 1;
  localparam longint VEL_MAX       = 64'sd524287;
  localparam longint VEL_MIN       = -VEL_MAX - 1;

  typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_t;

  // one line of the directed stimulus table
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    pmo_in_t                rq;
    bit                     typed;
    pmo_out_t               want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  pmo_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  pmo_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register shadow, tracked at each write
  longint k_gain = 256;
  longint k_tol [AXES] = '{256, 256, 256};
  bit     k_use_z = 1'b0;
  bit     k_use_switch = 1'b0;

  // move state mirrored from the block
  longint goal_pos [AXES] = '{0, 0, 0};
  longint odo_pos [AXES] = '{0, 0, 0};
  longint prev_vel [AXES] = '{0, 0, 0};
  bit     skip_first = 1'b1;
  bit     in_move = 1'b0;

  pmo_out_t  drive_expected [$];
  stim_row_t stim_rows [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  proportional_move_with_odometry dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run with an error report once cycle_count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver side: stall at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the mirrored move state by one request and return its result.
  function automatic pmo_out_t predict_drive(pmo_in_t rq);
    pmo_out_t res;
    longint   tgt [AXES];
    longint   vel [AXES];
    longint   err [AXES];
    longint   drv [AXES];
    longint   dt;
    bit       near_all;
    bit       sw;
    res = '0;
    tgt[0] = rq.target_x;
    tgt[1] = rq.target_y;
    tgt[2] = rq.target_z;
    vel[0] = rq.vel_x;
    vel[1] = rq.vel_y;
    vel[2] = rq.vel_z;
    dt = rq.tick_time;
    if (rq.action == ACT_START) begin
      // load a fresh relative goal, clear odometry, skip the next sample
      for (int a = 0; a < AXES; a++) begin
        goal_pos[a] = tgt[a];
        odo_pos[a]  = 0;
        prev_vel[a] = 0;
      end
      skip_first = 1'b1;
      in_move    = 1'b1;
    end else if (!in_move) begin
      return res;
    end else begin
      // trapezoid step: dt * (v + v_prev) / 2 in 2^-16 s, round half up
      for (int a = 0; a < AXES; a++) begin
        if (!skip_first)
          odo_pos[a] = sat(odo_pos[a] + ((dt * (vel[a] + prev_vel[a]) + 65536) >>> 17),
                           POS_MIN, POS_MAX);
        prev_vel[a] = vel[a];
      end
      skip_first = 1'b0;
    end
    near_all = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      err[a] = goal_pos[a] - odo_pos[a];
      if ((a < 2 || k_use_z) && ((err[a] < 0) ? -err[a] : err[a]) > k_tol[a])
        near_all = 1'b0;
    end
    sw = k_use_switch && rq.touch;
    if (near_all || sw) begin
      in_move = 1'b0;
      res.arrived = near_all;
      res.switch_stop = sw;
      return res;
    end
    for (int a = 0; a < AXES; a++)
      drv[a] = (a == 2 && !k_use_z) ? 0 : sat((err[a] * k_gain + 128) >>> 8, DRV_MIN, DRV_MAX);
    res.drive_x = DRV_W'(drv[0]);
    res.drive_y = DRV_W'(drv[1]);
    res.drive_z = DRV_W'(drv[2]);
    return res;
  endfunction

  task automatic report_error(string what);
    mismatch_count++;
    $display("mismatch, cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    pmo_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (drive_expected.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = drive_expected.pop_front();
        check_field("drive_x", 32'(out_data.drive_x), 32'(want.drive_x));
        check_field("drive_y", 32'(out_data.drive_y), 32'(want.drive_y));
        check_field("drive_z", 32'(out_data.drive_z), 32'(want.drive_z));
        check_field("arrived", 32'(out_data.arrived), 32'(want.arrived));
        check_field("switch_stop", 32'(out_data.switch_stop), 32'(want.switch_stop));
      end
    end
  end

  // Present one request, hold it through stalls, and log its expectation
  // at the accepting edge. A typed-in result replaces the predicted one.
  task automatic send_request(input pmo_in_t rq, input bit typed, input pmo_out_t want,
                              output pmo_out_t res);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = predict_drive(rq);
    if (typed)
      res = want;
    drive_expected.push_back(res);
  endtask

  // Drop valid and hold off until every result is back and the block settles.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GAIN:       k_gain = longint'(val);
      CFG_TOL_X:      k_tol[0] = longint'(val);
      CFG_TOL_Y:      k_tol[1] = longint'(val);
      CFG_TOL_Z:      k_tol[2] = longint'(val);
      CFG_USE_Z:      k_use_z = val[0];
      CFG_USE_SWITCH: k_use_switch = val[0];
      default: ;
    endcase
  endtask

  function automatic pmo_in_t mk_req(logic action, int tx, int ty, int tz,
                                     int vx, int vy, int vz, int dt, bit touch);
    pmo_in_t rq;
    rq.action    = action;
    rq.target_x  = GOAL_W'(tx);
    rq.target_y  = GOAL_W'(ty);
    rq.target_z  = GOAL_W'(tz);
    rq.vel_x     = VEL_W'(vx);
    rq.vel_y     = VEL_W'(vy);
    rq.vel_z     = VEL_W'(vz);
    rq.tick_time = DT_W'(dt);
    rq.touch     = touch;
    return rq;
  endfunction

  function automatic pmo_out_t mk_res(int dx, int dy, int dz, bit arr, bit sw);
    pmo_out_t r;
    r.drive_x     = DRV_W'(dx);
    r.drive_y     = DRV_W'(dy);
    r.drive_z     = DRV_W'(dz);
    r.arrived     = arr;
    r.switch_stop = sw;
    return r;
  endfunction

  function automatic stim_row_t req_row(pmo_in_t rq);
    stim_row_t row;
    row = '{ROW_REQUEST, '0, '0, rq, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t known_row(pmo_in_t rq, pmo_out_t want);
    stim_row_t row;
    row = '{ROW_REQUEST, '0, '0, rq, 1'b1, want};
    return row;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{ROW_WRITE, idx, val, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic pmo_in_t noise_request();
    pmo_in_t      rq;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    rq  = raw[$bits(pmo_in_t)-1:0];
    return rq;
  endfunction

  // Mostly nearby targets so moves can finish; some span the full range.
  function automatic pmo_in_t random_start();
    pmo_in_t rq;
    rq = noise_request();
    rq.action = ACT_START;
    if ($urandom_range(0, 4) != 0) begin
      rq.target_x = GOAL_W'($urandom_range(0, 60000) - 30000);
      rq.target_y = GOAL_W'($urandom_range(0, 60000) - 30000);
      rq.target_z = GOAL_W'($urandom_range(0, 60000) - 30000);
    end
    rq.touch = ($urandom_range(0, 19) == 0);
    return rq;
  endfunction

  // Close the loop: the axes roughly follow the last drive command.
  function automatic pmo_in_t plant_tick(pmo_out_t prev_res);
    pmo_in_t rq;
    int      jit;
    rq = noise_request();
    rq.action = ACT_TICK;
    if ($urandom_range(0, 7) != 0) begin
      jit = $urandom_range(0, 128);
      jit -= 64;
      rq.vel_x = VEL_W'(sat(longint'(prev_res.drive_x) + jit, VEL_MIN, VEL_MAX));
      jit = $urandom_range(0, 128);
      jit -= 64;
      rq.vel_y = VEL_W'(sat(longint'(prev_res.drive_y) + jit, VEL_MIN, VEL_MAX));
      jit = $urandom_range(0, 128);
      jit -= 64;
      rq.vel_z = VEL_W'(sat(longint'(prev_res.drive_z) + jit, VEL_MIN, VEL_MAX));
      rq.tick_time = DT_W'($urandom_range(4000, 40000));
    end
    rq.touch = ($urandom_range(0, 29) == 0);
    return rq;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      default: return CFG_DATA_W'($urandom_range(16, 1024));
    endcase
  endfunction

  // Idle the sender, the receiver, or both, by phase.
  task automatic set_idling(int phase);
    case (phase % 4)
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 80; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 80; end
      default: begin gap_pct = 26; stall_pct = 26; end
    endcase
  endtask

  task automatic phase_settings(int phase);
    drain_results();
    if (phase == 0) begin
      // wide tolerance, full gain, switch armed, two axes
      write_reg(CFG_GAIN, 16'hFFFF);
      write_reg(CFG_TOL_X, 16'hFFFF);
      write_reg(CFG_TOL_Y, 16'hFFFF);
      write_reg(CFG_TOL_Z, 16'hFFFF);
      write_reg(CFG_USE_Z, 16'd0);
      write_reg(CFG_USE_SWITCH, 16'd1);
    end else begin
      write_reg(CFG_GAIN, pick_level());
      write_reg(CFG_TOL_X, pick_level());
      write_reg(CFG_TOL_Y, pick_level());
      write_reg(CFG_TOL_Z, pick_level());
      write_reg(CFG_USE_Z, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_USE_SWITCH, CFG_DATA_W'($urandom_range(0, 1)));
    end
  endtask

  // Mostly whole moves (start then closed-loop ticks), the rest noise.
  task automatic run_moves(int n_items);
    int       sent;
    int       n_ticks;
    pmo_in_t  rq;
    pmo_out_t prev_res;
    sent = 0;
    prev_res = '0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        send_request(random_start(), 1'b0, '0, prev_res);
        sent++;
        n_ticks = $urandom_range(2, 24);
        for (int t = 0; t < n_ticks && in_move && sent < n_items; t++) begin
          rq = plant_tick(prev_res);
          send_request(rq, 1'b0, '0, prev_res);
          sent++;
        end
      end else begin
        rq = noise_request();
        send_request(rq, 1'b0, '0, prev_res);
        sent++;
      end
      // pause now and then until the block has answered everything
      if ($urandom_range(0, 39) == 0)
        drain_results();
    end
  endtask

  initial begin : stimulus
    pmo_out_t scratch;

    // Directed table; rows with a typed result read straight off the spec.
    // Reset settings: gain 1.0, tolerance 256, z and switch off.
    stim_rows.push_back(known_row(mk_req(ACT_TICK, 0, 0, 0, 524287, 524287, 524287, 65535, 1),
                                  mk_res(0, 0, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0),
                                  mk_res(0, 0, 0, 1, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_TICK, 0, 0, 0, 100, 100, 100, 100, 0),
                                  mk_res(0, 0, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 1000, -1000, 8388607, 0, 0, 0, 0, 1),
                                  mk_res(1000, -1000, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_TICK, 0, 0, 0, 524287, -524288, -1, 65535, 0),
                                  mk_res(1000, -1000, 0, 0, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 65535, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, -524288, 524287, 7, 0, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, 1, -1, 0, DIRECT_TICK, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 8388607, -8388608, 0, 0, 0, 0, 0, 0),
                                  mk_res(8388607, -8388608, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_TICK, 0, 0, 0, -524288, 524287, 0, 65535, 0),
                                  mk_res(8388607, -8388608, 0, 0, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, -524288, 524287, 0, 65535, 0)));
    // full gain: saturation and odd rounding
    stim_rows.push_back(write_row(CFG_GAIN, 16'hFFFF));
    stim_rows.push_back(known_row(mk_req(ACT_START, -1, 1, 0, 0, 0, 0, 0, 0),
                                  mk_res(0, 0, 0, 1, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_START, 300, 0, 0, 0, 0, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 8388607, -8388608, 0, 0, 0, 0, 0, 0),
                                  mk_res(8388607, -8388608, 0, 0, 0)));
    // switch armed: touch on a start, both end causes together, touch on a tick
    stim_rows.push_back(write_row(CFG_USE_SWITCH, 16'd1));
    stim_rows.push_back(known_row(mk_req(ACT_START, 5000, 0, 0, 0, 0, 0, 0, 1),
                                  mk_res(0, 0, 0, 0, 1)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 0, 0, 0, 0, 0, 0, 0, 1),
                                  mk_res(0, 0, 0, 1, 1)));
    stim_rows.push_back(req_row(mk_req(ACT_START, 5000, 0, 0, 0, 0, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_TICK, 0, 0, 0, 20, 20, 20, 1000, 1),
                                  mk_res(0, 0, 0, 0, 1)));
    // third axis on, half gain: negative half rounds up
    stim_rows.push_back(write_row(CFG_USE_Z, 16'd1));
    stim_rows.push_back(write_row(CFG_GAIN, 16'd128));
    stim_rows.push_back(req_row(mk_req(ACT_START, -3, 0, 1000, 0, 0, 0, 0, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 524287, 65535, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 524287, 65535, 0)));
    // tolerance extremes with zero gain
    stim_rows.push_back(write_row(CFG_TOL_X, 16'd0));
    stim_rows.push_back(write_row(CFG_TOL_Y, 16'hFFFF));
    stim_rows.push_back(write_row(CFG_TOL_Z, 16'd0));
    stim_rows.push_back(write_row(CFG_GAIN, 16'd0));
    stim_rows.push_back(known_row(mk_req(ACT_START, 1, 65535, 0, 0, 0, 0, 0, 0),
                                  mk_res(0, 0, 0, 0, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 0, -65535, 0, 0, 0, 0, 0, 0),
                                  mk_res(0, 0, 0, 1, 0)));
    stim_rows.push_back(known_row(mk_req(ACT_START, 0, -65536, 0, 0, 0, 0, 0, 0),
                                  mk_res(0, 0, 0, 0, 0)));
    stim_rows.push_back(req_row(mk_req(ACT_TICK, 0, 0, 0, 524287, -524288, 524287, 65535, 0)));

    // hold reset, then release it on a falling edge
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_request(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].want, scratch);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      phase_settings(p);
      set_idling(p);
      run_moves(PHASE_ITEMS);
    end

    drain_results();
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
